// ===== hw/rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
// Holds controller states and the command and status structs.
// No dependencies.
package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CFG_W            = 7;
  localparam logic [CFG_W-1:0] WINDOW_RST = 7'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_CK,
    S_PUSH,
    S_EV_RD,
    S_EV_CK,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic pop_rd;
    logic pop;
    logic push;
    logic ev_rd;
    logic evict;
    logic finish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic pop_hit;
    logic ev_hit;
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/swm_in_if.sv =====
// Input channel of the sliding window maximum block: valid, ready, sample, first.
// Depends on swm_pkg for the default sample width.
interface swm_in_if
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           first;

  modport source (output valid, output sample, output first, input ready);
  modport sink   (input valid, input sample, input first, output ready);
endinterface

// ===== hw/rtl/swm_out_if.sv =====
// Result channel of the sliding window maximum block: valid, ready, window_max.
// Depends on swm_pkg for the default sample width.
interface swm_out_if
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

// ===== hw/rtl/swm_ctrl.sv =====
// Controller for the sliding window maximum block: sequences pop, push,
// eviction and finish steps for each beat. Depends on swm_pkg.
module swm_ctrl
  import swm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_POP_RD;
        end
      end
      S_POP_RD: begin
        if (status.cnt_zero) begin
          state_nxt = S_PUSH;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP_CK;
        end
      end
      S_POP_CK: begin
        if (status.pop_hit) begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP_RD;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_EV_RD;
      end
      S_EV_RD: begin
        cmd.ev_rd = 1'b1;
        state_nxt = S_EV_CK;
      end
      S_EV_CK: begin
        // Keep the front on the read port so finish sees the maximum
        cmd.ev_rd = 1'b1;
        if (status.ev_hit) begin
          cmd.evict = 1'b1;
          state_nxt = S_EV_RD;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.ev_rd = 1'b1;
        // Hold until the output register can take the beat
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/swm_dp.sv =====
// Datapath for the sliding window maximum block: candidate deque memory,
// pointers, position and fill counters, window register, output register.
// Depends on swm_pkg.
module swm_dp
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_W-1:0]               cfg_wdata,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_first,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_window_max,
  input  cmd_t                           cmd,
  output status_t                        status
);

  localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int POS_W   = $clog2(POS_MOD);
  localparam int CMP_A   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CMP_W   = (CMP_A > CFG_W) ? CMP_A : CFG_W;

  // Candidate store
  logic signed [SAMPLE_WIDTH-1:0] mem_value [WINDOW_MAX];
  logic [POS_W-1:0]               mem_pos   [WINDOW_MAX];

  logic [CFG_W-1:0]               window_size_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic [PTR_W-1:0]               head_r;
  logic [PTR_W-1:0]               tail_r;
  logic [CNT_W-1:0]               count_r;
  logic [POS_W-1:0]               pos_r;
  logic [CNT_W-1:0]               filled_r;
  logic signed [SAMPLE_WIDTH-1:0] rd_value_r;
  logic [POS_W-1:0]               rd_pos_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_value_r;

  logic [PTR_W-1:0] tail_dec;
  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] rd_addr;
  logic [CMP_W-1:0] cfg_ext;
  logic [CNT_W-1:0] eff_k;
  logic [POS_W-1:0] age;
  logic [POS_W-1:0] pos_inc;
  logic [CNT_W-1:0] filled_inc;
  logic             store_full;

  // Pointer arithmetic modulo the store depth
  always_comb begin
    tail_dec = (tail_r == '0) ? PTR_W'(WINDOW_MAX - 1) : tail_r - 1'b1;
    tail_inc = (tail_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : tail_r + 1'b1;
    head_inc = (head_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : head_r + 1'b1;
    rd_addr  = cmd.ev_rd ? head_r : tail_dec;
    store_full = (count_r == CNT_W'(WINDOW_MAX));
  end

  // Effective window: zero acts as one, clamp at the store depth
  always_comb begin
    cfg_ext = CMP_W'(window_size_r);
    if (cfg_ext == '0) begin
      eff_k = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
      eff_k = CNT_W'(WINDOW_MAX);
    end else begin
      eff_k = CNT_W'(cfg_ext);
    end
  end

  // Age of the front candidate, positions wrap at twice the store depth
  always_comb begin
    age = pos_r - rd_pos_r;
    if (pos_r < rd_pos_r) begin
      age = age + POS_W'(POS_MOD);
    end
    pos_inc    = (pos_r == POS_W'(POS_MOD - 1)) ? '0 : pos_r + 1'b1;
    filled_inc = (filled_r == CNT_W'(WINDOW_MAX)) ? filled_r : filled_r + 1'b1;
  end

  // Status back to the controller
  always_comb begin
    status.cnt_zero = (count_r == '0);
    status.pop_hit  = (rd_value_r <= sample_r);
    status.ev_hit   = (CMP_W'(age) >= CMP_W'(eff_k));
    status.out_busy = out_valid_r && !out_ready;
  end

  // Window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_RST;
    end else if (cfg_we) begin
      window_size_r <= cfg_wdata;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_value[tail_r] <= sample_r;
      mem_pos[tail_r]   <= pos_r;
    end
    rd_value_r <= mem_value[rd_addr];
    rd_pos_r   <= mem_pos[rd_addr];
  end

  // Latch the incoming beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
    end
  end

  // Deque pointers, count, position and fill counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      pos_r    <= '0;
      filled_r <= '0;
    end else begin
      if (cmd.accept && in_first) begin
        head_r   <= '0;
        tail_r   <= '0;
        count_r  <= '0;
        pos_r    <= '0;
        filled_r <= '0;
      end
      if (cmd.pop) begin
        tail_r  <= tail_dec;
        count_r <= count_r - 1'b1;
      end
      if (cmd.push) begin
        tail_r <= tail_inc;
        // A full store drops its oldest entry, which is out of the window anyway
        if (store_full) begin
          head_r <= head_inc;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.evict) begin
        head_r  <= head_inc;
        count_r <= count_r - 1'b1;
      end
      if (cmd.finish) begin
        pos_r    <= pos_inc;
        filled_r <= filled_inc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish && (filled_inc >= eff_k)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r <= rd_value_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_value_r;

endmodule

// ===== hw/rtl/sliding_window_maximum.sv =====
// Sliding window maximum over the last window_size samples of a sequence.
// Each accepted beat is sequenced as pops of tail candidates no larger than the sample,
// a push of the sample, evictions of front candidates that have left the window, and a
// finish step; a previous result still held by out_ready low stalls the finish step.
// A new beat is taken only after the finish step, as the candidate memory has a single
// read port. Reset (rst_n, synchronous) clears counters and sets the window to 3;
// the candidate memory is not cleared.
module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  swm_in_if.sink           in_if,
  swm_out_if.source        out_if
);

  cmd_t    cmd;
  status_t status;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  swm_dp #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_sample      (in_if.sample),
    .in_first       (in_if.first),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_window_max (out_if.window_max),
    .cmd            (cmd),
    .status         (status)
  );

endmodule
